/* rtl/phad_pkg.sv */
`timescale 1ns / 1ps

package phad_pkg;

    // field widths
    localparam int LEVEL_W = 16;
    localparam int AGE_W   = 17;
    localparam int MULT_W  = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_FLOOR   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_CEILING = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DECAY   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_HOLD    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_TICK    = 3'd4;

    // operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // reset values
    localparam logic [LEVEL_W-1:0] FLOOR_RESET   = 16'hBE00;  // -66.0 dB
    localparam logic [LEVEL_W-1:0] CEILING_RESET = 16'h0C00;  // +12.0 dB
    localparam logic [15:0]        DECAY_RESET   = 16'd13;
    localparam logic [15:0]        HOLD_RESET    = 16'd500;
    localparam logic [7:0]         TICK_RESET    = 8'd17;

    // multiplier 1.0 in Q8.8, growth numerator over 256
    localparam logic [MULT_W-1:0] MULT_ONE   = 16'd256;
    localparam logic [AGE_W-1:0]  AGE_MAX    = '1;

    typedef struct packed {
        logic [LEVEL_W-1:0] floor_level;
        logic [LEVEL_W-1:0] ceiling_level;
        logic [15:0]        decay_per_tick;
        logic [15:0]        hold_ms;
        logic [7:0]         tick_ms;
    } t_cfg;

    typedef struct packed {
        logic [LEVEL_W-1:0] held;
        logic [AGE_W-1:0]   age;
        logic [MULT_W-1:0]  mult;
    } t_state;

endpackage

/* rtl/phad_cfg.sv */
`timescale 1ns / 1ps

module phad_cfg
    import phad_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    // register file, writes to unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_level    <= FLOOR_RESET;
            r_cfg.ceiling_level  <= CEILING_RESET;
            r_cfg.decay_per_tick <= DECAY_RESET;
            r_cfg.hold_ms        <= HOLD_RESET;
            r_cfg.tick_ms        <= TICK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FLOOR:   r_cfg.floor_level    <= i_cfg_wdata;
                CFG_CEILING: r_cfg.ceiling_level  <= i_cfg_wdata;
                CFG_DECAY:   r_cfg.decay_per_tick <= i_cfg_wdata;
                CFG_HOLD:    r_cfg.hold_ms        <= i_cfg_wdata;
                CFG_TICK:    r_cfg.tick_ms        <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/phad_step.sv */
`timescale 1ns / 1ps

module phad_step
    import phad_pkg::*;
(
    input  t_cfg               i_cfg,
    input  t_state             i_cur,
    input  logic               i_operation,
    input  logic [LEVEL_W-1:0] i_level,
    input  logic               i_force_floor,
    output t_state             o_nxt
);

    logic [AGE_W:0]        age_sum;
    logic [AGE_W-1:0]      age_sat;
    logic [31:0]           decay_prod;
    logic [23:0]           amount;
    logic signed [25:0]    lvl_sub;
    logic signed [25:0]    ceil_ext;
    logic signed [25:0]    floor_ext;
    logic signed [25:0]    lvl_hi;
    logic signed [25:0]    lvl_clamp;
    logic [LEVEL_W-1:0]    held_dec;
    logic [19:0]           grow_prod;
    logic [MULT_W:0]       grow_sum;
    logic [MULT_W-1:0]     mult_grow;

    // age advance with saturation
    assign age_sum = (AGE_W+1)'(i_cur.age) + (AGE_W+1)'(i_cfg.tick_ms);
    assign age_sat = age_sum[AGE_W] ? AGE_MAX : age_sum[AGE_W-1:0];

    // decay amount, truncated Q8.8 product
    assign decay_prod = 32'(i_cfg.decay_per_tick) * 32'(i_cur.mult);
    assign amount     = decay_prod[31:8];

    // subtract and clamp, ceiling first so the floor wins
    assign lvl_sub   = 26'($signed(i_cur.held)) - $signed({2'b00, amount});
    assign ceil_ext  = 26'($signed(i_cfg.ceiling_level));
    assign floor_ext = 26'($signed(i_cfg.floor_level));
    assign lvl_hi    = (lvl_sub > ceil_ext) ? ceil_ext : lvl_sub;
    assign lvl_clamp = (lvl_hi < floor_ext) ? floor_ext : lvl_hi;
    assign held_dec  = lvl_clamp[LEVEL_W-1:0];

    // multiplier growth m += m*13 >> 8, saturating
    assign grow_prod = {1'b0, i_cur.mult, 3'b000} + {2'b00, i_cur.mult, 2'b00}
                     + {4'b0000, i_cur.mult};
    assign grow_sum  = (MULT_W+1)'(i_cur.mult) + (MULT_W+1)'(grow_prod[19:8]);
    assign mult_grow = grow_sum[MULT_W] ? {MULT_W{1'b1}} : grow_sum[MULT_W-1:0];

    // next state select
    always_comb begin
        o_nxt = i_cur;
        case (i_operation)
            OP_TICK: begin
                o_nxt.age = age_sat;
                if (age_sat > AGE_W'(i_cfg.hold_ms)) begin
                    o_nxt.held = held_dec;
                    if ($signed(held_dec) <= $signed(i_cfg.floor_level)) begin
                        o_nxt.mult = MULT_ONE;
                    end else begin
                        o_nxt.mult = mult_grow;
                    end
                end
            end
            default: begin
                if ($signed(i_level) > $signed(i_cur.held)) begin
                    o_nxt.held = i_level;
                    o_nxt.age  = '0;
                    o_nxt.mult = MULT_ONE;
                end
                if (i_force_floor) begin
                    o_nxt.held = i_cfg.floor_level;
                end
            end
        endcase
    end

endmodule

/* rtl/peak_hold_accelerating_decay.sv */
`timescale 1ns / 1ps

// Peak-hold level tracker with accelerating decay for a dB meter. Each item on
// the slave stream is a level sample (tuser 0) or a frame tick (tuser 1) and
// yields exactly one result: the held level in Q7.8 dB and a flag that the hold
// time has run out. One item can be taken every cycle while the master stream takes
// results; its result is registered as it moves on from the input register to the
// result register, while the state update settles in front of the result register,
// whose longest path is the 16 by 16 decay multiply followed by the subtract and
// clamp. A result left waiting on the master stream lets one more item into the
// input register and then stalls the slave stream. Configuration is to be written
// through the plain write port only while the stream is idle, which the block
// itself does not enforce; it takes effect from the next item.
module peak_hold_accelerating_decay
    import phad_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write port
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    // slave stream
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [23:0]      i_s_axis_tdata,  // [15:0] level, [16] force_floor, rest zero
    input  logic             i_s_axis_tuser,  // [0] operation
    // master stream
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata   // [15:0] held_level, [16] decaying, rest zero
);

    t_cfg               cfg;
    t_state             r_state;
    t_state             n_state;
    logic               r_in_valid;
    logic               r_in_op;
    logic [LEVEL_W-1:0] r_in_level;
    logic               r_in_force_floor;
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_held;
    logic               r_out_decaying;
    logic               advance;
    logic               in_take;

    phad_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    phad_step u_step (
        .i_cfg         (cfg),
        .i_cur         (r_state),
        .i_operation   (r_in_op),
        .i_level       (r_in_level),
        .i_force_floor (r_in_force_floor),
        .o_nxt         (n_state)
    );

    // stage handshake
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (in_take) begin
            r_in_op          <= i_s_axis_tuser;
            r_in_level       <= i_s_axis_tdata[15:0];
            r_in_force_floor <= i_s_axis_tdata[16];
        end
    end

    // tracker state, updated as each item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.held <= FLOOR_RESET;
            r_state.age  <= '0;
            r_state.mult <= MULT_ONE;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_held     <= n_state.held;
            r_out_decaying <= n_state.age > AGE_W'(cfg.hold_ms);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_decaying, r_out_held};

    // state moves only together with a result
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("tracker state changed without a transfer into the result register");

    // the pending result always reflects the current held level
    a_out_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_held == r_state.held))
        else $error("result held level differs from tracker state");

    // a new peak restarts the age and the multiplier
    a_peak_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_op == OP_SAMPLE && $signed(r_in_level) > $signed(r_state.held))
        |=> (r_state.age == '0 && r_state.mult == MULT_ONE))
        else $error("new peak did not clear age and multiplier");

    // the multiplier never collapses to zero, and each transfer leaves a valid result
    a_mult_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_state.mult != '0 && r_out_valid))
        else $error("multiplier reached zero or result lost");

endmodule
